// ===== rtl/ttcs_pkg.sv =====
// shared widths, character codes, types and defaults for the text terminal cursor engine
package ttcs_pkg;

  // field widths
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 7;
  localparam int unsigned CharW = 8;

  // stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  // default screen geometry
  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 30;

  // control characters
  localparam logic [CharW-1:0] CodeCr  = 8'd13;
  localparam logic [CharW-1:0] CodeLf  = 8'd10;
  localparam logic [CharW-1:0] CodeBs  = 8'd8;
  localparam logic [CharW-1:0] CodeDel = 8'd127;

  // request kinds on tuser
  localparam logic FuncPut  = 1'b0;
  localparam logic FuncLeft = 1'b1;

  // cursor and scroll state
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [RowW-1:0] top;
  } ttcs_state_t;

  // one result item
  typedef struct packed {
    logic             cell_write;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_col;
    logic [CharW-1:0] cell_char;
    logic             clear_row_valid;
    logic [RowW-1:0]  clear_row_index;
    logic [RowW-1:0]  cursor_row_out;
    logic [ColW-1:0]  cursor_col_out;
    logic [RowW-1:0]  top_row_out;
  } ttcs_result_t;

endpackage

// ===== rtl/ttcs_step.sv =====
// single-pass cursor, wrap and scroll update for one request
module ttcs_step #(
  parameter int unsigned COLUMNS = ttcs_pkg::DefColumns,
  parameter int unsigned ROWS    = ttcs_pkg::DefRows
) (
  input  ttcs_pkg::ttcs_state_t              state_i,
  input  logic                               func_i,
  input  logic [ttcs_pkg::CharW-1:0]         char_i,
  output ttcs_pkg::ttcs_state_t              state_o,
  output ttcs_pkg::ttcs_result_t             res_o
);

  localparam logic [ttcs_pkg::RowW-1:0] RowLast = ttcs_pkg::RowW'(ROWS - 1);
  localparam logic [ttcs_pkg::ColW-1:0] ColLast = ttcs_pkg::ColW'(COLUMNS - 1);

  logic                      is_newline;
  logic                      is_erase;
  logic                      do_left;
  logic [ttcs_pkg::RowW-1:0] row_inc;
  logic [ttcs_pkg::RowW-1:0] row_dec;
  logic [ttcs_pkg::RowW-1:0] top_inc;
  logic [ttcs_pkg::RowW-1:0] left_row;
  logic [ttcs_pkg::ColW-1:0] left_col;
  logic                      scroll;

  // decode and neighbor rows in the ring
  always_comb begin
    is_newline = (char_i == ttcs_pkg::CodeCr) || (char_i == ttcs_pkg::CodeLf);
    is_erase   = (char_i == ttcs_pkg::CodeBs) || (char_i == ttcs_pkg::CodeDel);
    do_left    = (func_i == ttcs_pkg::FuncLeft) || is_erase;
    row_inc    = (state_i.row == RowLast) ? '0 : state_i.row + 1'b1;
    row_dec    = (state_i.row == '0) ? RowLast : state_i.row - 1'b1;
    top_inc    = (state_i.top == RowLast) ? '0 : state_i.top + 1'b1;
    scroll     = (row_inc == state_i.top);
  end

  // cursor one cell to the left, stopping at the top row
  always_comb begin
    left_row = state_i.row;
    left_col = state_i.col;
    if (state_i.col != '0) begin
      left_col = state_i.col - 1'b1;
    end else if (state_i.row != state_i.top) begin
      left_row = row_dec;
      left_col = ColLast;
    end
  end

  // next state and result
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (do_left) begin
      state_o.row = left_row;
      state_o.col = left_col;
      if (func_i == ttcs_pkg::FuncPut) begin
        res_o.cell_write = 1'b1;
        res_o.cell_row   = left_row;
        res_o.cell_col   = left_col;
      end
    end else begin
      if (!is_newline) begin
        res_o.cell_write = 1'b1;
        res_o.cell_row   = state_i.row;
        res_o.cell_col   = state_i.col;
        res_o.cell_char  = char_i;
      end
      if (is_newline || (state_i.col == ColLast)) begin
        // new line, scrolling when it lands on the top row
        state_o.row = row_inc;
        state_o.col = '0;
        if (scroll) begin
          state_o.top           = top_inc;
          res_o.clear_row_valid = 1'b1;
          res_o.clear_row_index = row_inc;
        end
      end else begin
        state_o.col = state_i.col + 1'b1;
      end
    end
    res_o.cursor_row_out = state_o.row;
    res_o.cursor_col_out = state_o.col;
    res_o.top_row_out    = state_o.top;
  end

endmodule

// ===== rtl/text_terminal_cursor_scroll_top.sv =====
// Text terminal cursor and scroll engine: each request (put a character or move left) yields
// exactly one result with an optional cell write, an optional whole-row clear after a scroll,
// and the cursor and top row as they stand afterwards. One request is taken every clock cycle
// while the result side is not stalled. A request passes an input register, the single-pass
// cursor logic and the result register, which holds it while the downstream side stalls. The
// result is written into the result register once that is free, and the cursor state feeds
// back from the single-pass update into the next request.
module text_terminal_cursor_scroll_top #(
  parameter int unsigned COLUMNS = ttcs_pkg::DefColumns,
  parameter int unsigned ROWS    = ttcs_pkg::DefRows
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] char_code
  input  logic [ttcs_pkg::InDataW-1:0]      s_axis_tdata_i,
  // [0] func
  input  logic [0:0]                        s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] cell_write, [5:1] cell_row, [12:6] cell_col, [20:13] cell_char,
  // [21] clear_row_valid, [26:22] clear_row_index, [31:27] cursor_row_out,
  // [38:32] cursor_col_out, [43:39] top_row_out, [47:44] zero
  output logic [ttcs_pkg::OutDataW-1:0]     m_axis_tdata_o
);

  logic                           in_valid_q;
  logic                           func_q;
  logic [ttcs_pkg::CharW-1:0]     char_q;
  logic                           out_valid_q;
  ttcs_pkg::ttcs_result_t         res_q;
  ttcs_pkg::ttcs_result_t         res_d;
  ttcs_pkg::ttcs_state_t          state_q;
  ttcs_pkg::ttcs_state_t          state_d;
  logic                           out_free;
  logic                           fire;

  // handshake control
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      func_q <= s_axis_tuser_i[0];
      char_q <= s_axis_tdata_i;
    end
  end

  // cursor update
  ttcs_step #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_step (
    .state_i (state_q),
    .func_i  (func_q),
    .char_i  (char_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // result packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000,
                            res_q.top_row_out,
                            res_q.cursor_col_out,
                            res_q.cursor_row_out,
                            res_q.clear_row_index,
                            res_q.clear_row_valid,
                            res_q.cell_char,
                            res_q.cell_col,
                            res_q.cell_row,
                            res_q.cell_write};

endmodule

// ===== rtl/ttcs_checker.sv =====
// port-level checks for the text terminal cursor engine, bound to the top level
module ttcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ttcs_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // no cell write means zero cell fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[20:1] == '0)
    else $error("cell fields set without a cell write");

  // no clear means zero clear index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[21] |-> m_axis_tdata_o[26:22] == '0)
    else $error("clear index set without a clear");

  // a cleared row is the fresh cursor row, at column zero, below a different top row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[21] |->
      m_axis_tdata_o[26:22] == m_axis_tdata_o[31:27] && m_axis_tdata_o[38:32] == '0 &&
      m_axis_tdata_o[43:39] != m_axis_tdata_o[31:27])
    else $error("clear row does not match the new cursor line");

endmodule

bind text_terminal_cursor_scroll_top ttcs_checker u_ttcs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
